// ----- rtl/core/bros_pkg.sv -----
package bros_pkg;

	// Fixed field widths
	localparam int LLR_WIDTH  = 8;
	localparam int INDEX_W    = 5;
	localparam int SUM_W      = 15;
	localparam int BITS_W     = 8;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_BLOCKS     = 20;
	localparam int DEF_MAX_BLOCK_BITS = 128;

	// Block length register reset value and confidence ceiling
	localparam logic [BITS_W-1:0] BLOCK_BITS_RESET = 8'd128;
	localparam logic [SUM_W-1:0]  SUM_MAX          = 15'h7FFF;

	// Result status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic signed [LLR_WIDTH-1:0] llr;
		logic                        frame_end;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] block_index;
		logic [SUM_W-1:0]   block_confidence;
		logic               status;
		logic               last;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic step;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_out;
	} dp_stat_t;

endpackage

// ----- rtl/core/bros_ctrl.sv -----
module bros_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              frame_end,
	input  bros_pkg::dp_stat_t stat,
	output bros_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import bros_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	// Take samples while idle, drain the table after the frame end
	always_comb begin
		cmd.step = (state_q == S_IDLE) && start;
		cmd.emit = (state_q == S_EMIT);
		busy     = (state_q == S_EMIT);
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && frame_end) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.last_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/bros_dp.sv -----
module bros_dp #(
	parameter int MAX_BLOCKS     = bros_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_BLOCK_BITS = bros_pkg::DEF_MAX_BLOCK_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bros_pkg::dp_cmd_t             cmd,
	input  bros_pkg::item_t               item,
	input  logic                          cfg_we,
	input  logic [bros_pkg::BITS_W-1:0]   cfg_data,
	output bros_pkg::dp_stat_t            stat,
	output logic                          result_valid,
	output bros_pkg::result_t             result
);
	import bros_pkg::*;

	localparam int CNT_W = $clog2(MAX_BLOCK_BITS + 1);
	localparam int CW    = $clog2(MAX_BLOCKS + 1);

	logic [BITS_W-1:0] bits_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic [CW-1:0]     count_q;

	logic [SUM_W-1:0]   conf_q [MAX_BLOCKS];
	logic [INDEX_W-1:0] idx_q  [MAX_BLOCKS];
	logic [SUM_W-1:0]   conf_d [MAX_BLOCKS];
	logic [INDEX_W-1:0] idx_d  [MAX_BLOCKS];

	logic              valid_q;
	result_t           res_q;

	logic [BITS_W-1:0]    eff_bits;
	logic [LLR_WIDTH-1:0] mag;
	logic [SUM_W:0]       sum_ext;
	logic [SUM_W-1:0]     sum_sat;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 blk_done;
	logic                 room;
	logic                 do_insert;
	logic                 err;
	logic [MAX_BLOCKS-1:0] gt;
	logic [MAX_BLOCKS-1:0] prev_gt;

	// Clamp block length, accumulate magnitude with saturation
	always_comb begin
		eff_bits = bits_q;
		if (bits_q == '0) eff_bits = 8'd1;
		if (bits_q > BITS_W'(MAX_BLOCK_BITS)) eff_bits = BITS_W'(MAX_BLOCK_BITS);
		mag      = item.llr[LLR_WIDTH-1] ? (~item.llr + 1'b1) : item.llr;
		sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(mag);
		sum_sat  = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];
		cnt_inc  = cnt_q + 1'b1;
		blk_done = (9'(cnt_inc) >= 9'(eff_bits));
		room     = (count_q < CW'(MAX_BLOCKS));
		do_insert = cmd.step && blk_done && room;
		err      = (cnt_q != '0) || ovf_q || (count_q == '0);
		stat.last_out = err || (count_q == CW'(1));
	end

	// Compare the new block against every stored entry at once
	always_comb begin
		for (int p = 0; p < MAX_BLOCKS; p++) begin
			gt[p] = (CW'(p) < count_q) && (conf_q[p] > sum_sat);
		end
		prev_gt = gt << 1;
	end

	// Stable insert on block completion, shift toward the head on emit
	always_comb begin
		for (int p = 0; p < MAX_BLOCKS; p++) begin
			conf_d[p] = conf_q[p];
			idx_d[p]  = idx_q[p];
		end
		if (do_insert) begin
			for (int p = 0; p < MAX_BLOCKS; p++) begin
				if ((gt[p] || (CW'(p) == count_q)) && !prev_gt[p]) begin
					conf_d[p] = sum_sat;
					idx_d[p]  = INDEX_W'(count_q);
				end
			end
			for (int p = 1; p < MAX_BLOCKS; p++) begin
				if (prev_gt[p]) begin
					conf_d[p] = conf_q[p-1];
					idx_d[p]  = idx_q[p-1];
				end
			end
		end else if (cmd.emit && !err) begin
			for (int p = 0; p < MAX_BLOCKS - 1; p++) begin
				conf_d[p] = conf_q[p+1];
				idx_d[p]  = idx_q[p+1];
			end
		end
	end

	// Hold the sorted table
	always_ff @(posedge clk) begin
		for (int p = 0; p < MAX_BLOCKS; p++) begin
			conf_q[p] <= conf_d[p];
			idx_q[p]  <= idx_d[p];
		end
	end

	// Frame counters and block length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= BLOCK_BITS_RESET;
			cnt_q   <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_we) bits_q <= cfg_data;
			if (cmd.step) begin
				if (blk_done) begin
					cnt_q <= '0;
					sum_q <= '0;
					if (room) count_q <= count_q + 1'b1;
					else      ovf_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_inc;
					sum_q <= sum_sat;
				end
			end else if (cmd.emit) begin
				if (stat.last_out) begin
					cnt_q   <= '0;
					sum_q   <= '0;
					ovf_q   <= 1'b0;
					count_q <= '0;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// Register the outgoing transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.block_index      <= err ? '0 : idx_q[0];
			res_q.block_confidence <= err ? '0 : conf_q[0];
			res_q.status           <= err ? STATUS_ERR : STATUS_OK;
			res_q.last             <= stat.last_out;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

// ----- rtl/core/block_reliability_order_sorter_top.sv -----
// Sorts the blocks of a soft-decision frame weakest first. One sample is taken
// per cycle while busy is low; each completed block is inserted into the sorted
// table in the same cycle it completes, by comparing it against all stored
// entries in parallel. After the sample flagged frame_end, busy stays high while
// the single result port drains the table one entry a cycle, one result per
// block in the frame or a single result for a malformed frame. Each result
// appears for exactly one cycle with result_valid high and must be taken then:
// there is no way to stall the output. A bad length or too many blocks gives
// one result with status set, index and confidence zero, and last set.
module block_reliability_order_sorter_top #(
	parameter int MAX_BLOCKS     = bros_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_BLOCK_BITS = bros_pkg::DEF_MAX_BLOCK_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bros_pkg::item_t             item,
	output logic                        busy,
	input  logic                        cfg_we,
	input  logic [bros_pkg::BITS_W-1:0] cfg_data,
	output logic                        result_valid,
	output bros_pkg::result_t           result
);
	import bros_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bros_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.frame_end (item.frame_end),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	bros_dp #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.MAX_BLOCK_BITS (MAX_BLOCK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	// An error result is always the only result of its frame
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == STATUS_ERR) |-> result.last)
		else $error("error result without last");

	// Draining produces one transfer per busy cycle
	a_busy_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> result_valid)
		else $error("busy cycle without result");

	// The final result returns the block to accepting samples
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("still busy after last result");

	// Draining starts only after an accepted frame end
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && item.frame_end))
		else $error("busy without frame end");

endmodule

// ----- verif/block_reliability_order_sorter_top_tb.sv -----
`timescale 1ns / 100ps

module block_reliability_order_sorter_top_tb;
	import bros_pkg::*;

	localparam int MAX_BLOCKS   = DEF_MAX_BLOCKS;
	localparam int RANDOM_ITEMS = 370;
	localparam int DRAIN_LIMIT  = 200;

	// Predicts the weakest-first block order and checks the result transfers
	class sort_scoreboard;
		logic [BITS_W-1:0]  block_len = BLOCK_BITS_RESET;
		int unsigned        fill;
		int unsigned        n_blocks;
		int unsigned        run_sum;
		bit                 overflow;
		logic [SUM_W-1:0]   conf_tab[MAX_BLOCKS];
		logic [INDEX_W-1:0] idx_tab[MAX_BLOCKS];
		result_t            expected_q[$];
		int                 errors;
		int                 n_samples;
		int                 n_frames;
		int                 n_block_results;
		int                 n_error_results;

		function void write_block_bits(logic [BITS_W-1:0] v);
			block_len = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Register 0 acts as 1, values past the table width clamp
		function int unsigned block_samples();
			if (block_len == 0)
				return 1;
			if (block_len > DEF_MAX_BLOCK_BITS)
				return DEF_MAX_BLOCK_BITS;
			return block_len;
		endfunction

		function void clear_frame();
			fill = 0;
			n_blocks = 0;
			run_sum = 0;
			overflow = 0;
		endfunction

		// Stable insert: equal confidences stay in block order
		function void insert_block(int unsigned conf);
			int unsigned pos;
			pos = n_blocks;
			while (pos > 0 && conf_tab[pos-1] > conf) begin
				conf_tab[pos] = conf_tab[pos-1];
				idx_tab[pos] = idx_tab[pos-1];
				pos--;
			end
			conf_tab[pos] = conf[SUM_W-1:0];
			idx_tab[pos] = n_blocks[INDEX_W-1:0];
			n_blocks++;
		endfunction

		function void note_sample(item_t it);
			int v;
			result_t r;
			v = $signed(it.llr);
			n_samples++;
			run_sum += (v < 0) ? -v : v;
			if (run_sum > SUM_MAX)
				run_sum = SUM_MAX;
			fill++;
			if (fill >= block_samples()) begin
				if (n_blocks < MAX_BLOCKS)
					insert_block(run_sum);
				else
					overflow = 1;
				fill = 0;
				run_sum = 0;
			end
			if (!it.frame_end)
				return;
			n_frames++;
			if (fill != 0 || overflow || n_blocks == 0) begin
				r = '{block_index: '0, block_confidence: '0, status: STATUS_ERR, last: 1'b1};
				expected_q.push_back(r);
			end else begin
				for (int k = 0; k < n_blocks; k++) begin
					r.block_index = idx_tab[k];
					r.block_confidence = conf_tab[k];
					r.status = STATUS_OK;
					r.last = (k + 1 == n_blocks);
					expected_q.push_back(r);
				end
			end
			clear_frame();
		endfunction

		function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: block_index %0d block_confidence %0d status %0d",
					r.block_index, r.block_confidence, r.status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (e.status == STATUS_ERR)
				n_error_results++;
			else
				n_block_results++;
			compare_field("block_index", 16'(e.block_index), 16'(r.block_index));
			compare_field("block_confidence", 16'(e.block_confidence),
				16'(r.block_confidence));
			compare_field("status", 16'(e.status), 16'(r.status));
			compare_field("last", 16'(e.last), 16'(r.last));
		endfunction

		// Report and drop results that never came
		function void flush_missing();
			result_t e;
			while (expected_q.size() != 0) begin
				e = expected_q.pop_front();
				$error("missing result: block_index %0d block_confidence %0d status %0d",
					e.block_index, e.block_confidence, e.status);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	item_t             item = '0;
	logic              busy;
	logic              cfg_we = 1'b0;
	logic [BITS_W-1:0] cfg_data = '0;
	logic              result_valid;
	result_t           result;

	sort_scoreboard sb = new();
	int random_sent;

	block_reliability_order_sorter_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Observe register writes, result transfers and sample transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_block_bits(cfg_data);
			if (result_valid)
				sb.check_result(result);
			if (start && !busy)
				sb.note_sample(item);
		end
	end

	// Mostly no gap, sometimes short, rarely long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Full range, extremes, or small values that make ties likely
	function automatic logic [LLR_WIDTH-1:0] rand_llr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(0, 255));
		if (r < 85)
			return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
		return 8'($signed($urandom_range(0, 4)) - 2);
	endfunction

	// Hold the sample until it is taken, then idle for the requested gap
	task automatic send_sample(input logic [LLR_WIDTH-1:0] llr_v, input logic fe,
			input int gap);
		start <= 1'b1;
		item <= '{llr: llr_v, frame_end: fe};
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_block_bits(input logic [BITS_W-1:0] v);
		start <= 1'b0;
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every expected result, then let the block settle
	task automatic wait_drained();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		sb.flush_missing();
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_frame(input int n, input bit quiet);
		for (int i = 0; i < n; i++) begin
			send_sample(rand_llr(), i == n - 1, quiet ? 0 : idle_len());
			random_sent++;
		end
	endtask

	// Pick a frame shape: full table, too many blocks, short block or normal
	task automatic run_random_frame(input int blen);
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 15)
			n = MAX_BLOCKS * blen;
		else if (r < 25)
			n = (MAX_BLOCKS + $urandom_range(1, 2)) * blen;
		else if (r < 40)
			n = $urandom_range(0, 6) * blen + ((blen > 1) ? $urandom_range(1, blen - 1) : 0);
		else
			n = $urandom_range(1, 8) * blen;
		if (n == 0)
			n = 1;
		send_frame(n, $urandom_range(0, 3) == 0);
	endtask

	initial begin
		int raw_len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset length of 128: a lone final sample leaves a short block
		send_sample(8'sd100, 1'b1, 0);
		wait_drained();

		// Length 0 acts as 1: extremes sort as 0, 1, 127, 128
		set_block_bits(8'd0);
		send_sample(8'sd127, 1'b0, 0);
		send_sample(8'h80, 1'b0, 1);
		send_sample(8'sd0, 1'b0, 0);
		send_sample(-8'sd1, 1'b1, 0);

		// Equal confidences keep block order
		send_sample(8'sd5, 1'b0, 2);
		send_sample(-8'sd5, 1'b0, 0);
		send_sample(8'sd5, 1'b1, 0);
		wait_drained();

		// Three samples at length two end on a short block
		set_block_bits(8'd2);
		send_sample(8'sd40, 1'b0, 0);
		send_sample(-8'sd40, 1'b0, 0);
		send_sample(8'sd1, 1'b1, 0);
		wait_drained();

		// Change the length mid-frame: the second block holds one sample
		send_sample(8'sd7, 1'b0, 0);
		send_sample(8'sd9, 1'b0, 0);
		set_block_bits(8'd1);
		send_sample(-8'sd3, 1'b1, 0);
		wait_drained();

		// Length past the table width clamps to 128
		set_block_bits(8'd255);
		send_frame(DEF_MAX_BLOCK_BITS, 1'b0);
		wait_drained();
		set_block_bits(8'd96);
		send_frame(50, 1'b0);
		wait_drained();

		// Random phases of short block lengths
		while (random_sent < RANDOM_ITEMS) begin
			raw_len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
			set_block_bits(BITS_W'(raw_len));
			repeat ($urandom_range(2, 4))
				if (random_sent < RANDOM_ITEMS)
					run_random_frame((raw_len == 0) ? 1 : raw_len);
			wait_drained();
		end

		wait_drained();
		repeat (MAX_BLOCKS + 5) @(posedge clk);
		$display("run covered %0d samples in %0d frames", sb.n_samples, sb.n_frames);
		$display("checked %0d block results and %0d error results",
			sb.n_block_results, sb.n_error_results);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
